// ===== design/gdf_pkg.sv =====
// Shared types and constants for the group-addressed DMX fader.
// Used by gdf_cell, gdf_proc and group_address_dmx_fader; depends on nothing.

package gdf_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W    = 8;

    localparam logic [1:0] TPCI_CHECK_MASK = 2'b11;
    localparam logic [7:0] APCI_KIND_MASK  = 8'hC0;
    localparam logic [7:0] APCI_WRITE      = 8'h80;
    localparam logic [7:0] APCI_SHORT_MASK = 8'h3F;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_TELEGRAM = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    // One channel table entry as it travels around the ring.
    typedef struct packed {
        logic        valid;
        logic [15:0] group;
        logic [3:0]  universe;
        logic [8:0]  slot;
        logic [16:0] step;
        logic [7:0]  target;
        logic [15:0] fine;
        logic [7:0]  shown;
    } entry_t;

    // The accepted command, held for the whole walk around the ring.
    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  index;
        logic [15:0] group;
        logic [3:0]  universe;
        logic [8:0]  slot;
        logic [16:0] step;
        logic        telegram_ok;
        logic [7:0]  value;
    } item_t;

    typedef struct packed {
        logic       has_result;
        logic [3:0] universe;
        logic [8:0] slot;
        logic [7:0] level;
        logic       changed;
    } result_t;

endpackage

// ===== design/group_address_dmx_fader.sv =====
// Top level of the group-addressed DMX fader: command intake, ring of channel
// cells, head update logic and result register. Depends on gdf_pkg, gdf_cell, gdf_proc.
//
//  Channel | Direction | Ports                         | Carries
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | load, telegram or tick command
//  m_      | out       | m_tvalid m_tready m_tdata m_tlast | one level report per valid channel
//
// Every command is taken at intake in idle and then walks the whole ring, all
// CHANNELS entries, before the next command is accepted.
// The walk length is set by the ring of cells passing one entry a cycle through
// the single update unit at its head. A result that cannot be handed to the
// output register holds the ring still. Reset is synchronous and active low;
// it clears the channel valid bits, so the table is empty after reset.

module group_address_dmx_fader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0 up: entry_index[3:0], group_address[15:0],
    // dmx_universe[3:0], dmx_slot[8:0], fade_step[16:0], tpci_byte[7:0],
    // apci_byte[7:0], data_byte[7:0], short_frame, zero fill to 80 bits.
    input  logic [79:0] s_tdata,
    // s_tuser: command[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0 up: out_universe[3:0], out_slot[8:0],
    // out_level[7:0], changed, zero fill to 24 bits.
    output logic [23:0] m_tdata,
    // m_tlast: the final report of a tick.
    output logic        m_tlast
);
    import gdf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    count_reg;
    item_t               item_reg;
    logic [CHANNELS-1:0] mask_reg;
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;
    logic                m_tlast_reg;

    entry_t              cell_q [CHANNELS];
    entry_t              head_next;
    result_t             res;
    logic [CHANNELS-1:0] valid_now;
    logic [CHANNELS:0]   rest;
    logic                is_last;
    logic                out_free;
    logic                shift_en;
    logic                s_fire;
    item_t               item_next;
    logic [7:0]          tpci_b;
    logic [7:0]          apci_b;

    // Intake: decode the telegram check and the written value once per command.
    assign tpci_b = s_tdata[57:50];
    assign apci_b = s_tdata[65:58];

    always_comb begin
        item_next.cmd         = cmd_t'(s_tuser);
        item_next.index       = s_tdata[3:0];
        item_next.group       = s_tdata[19:4];
        item_next.universe    = s_tdata[23:20];
        item_next.slot        = s_tdata[32:24];
        item_next.step        = s_tdata[49:33];
        item_next.telegram_ok = ((tpci_b[1:0] & TPCI_CHECK_MASK) == 2'b00) &&
                                ((apci_b & APCI_KIND_MASK) == APCI_WRITE);
        item_next.value       = s_tdata[74] ? (apci_b & APCI_SHORT_MASK) : s_tdata[73:66];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // The ring turns once a cycle during a walk unless a report is waiting for room.
    assign out_free = !m_tvalid_reg || m_tready;
    assign shift_en = (state_reg == ST_WALK) && (!res.has_result || out_free);

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_ring
            entry_t cell_in;
            if (gi == CHANNELS - 1) begin : g_tail
                assign cell_in = head_next;
            end else begin : g_mid
                assign cell_in = cell_q[gi + 1];
            end
            gdf_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .entry_in  (cell_in),
                .entry_out (cell_q[gi])
            );
            assign valid_now[gi] = cell_q[gi].valid;
        end
    endgenerate

    gdf_proc u_proc (
        .item      (item_reg),
        .pos       (count_reg),
        .entry_in  (cell_q[0]),
        .entry_out (head_next),
        .res       (res)
    );

    // A report is the last of its tick when no valid channel lies beyond it.
    assign rest    = {1'b0, mask_reg} >> count_reg;
    assign is_last = (rest[CHANNELS:1] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        item_reg  <= item_next;
                        mask_reg  <= valid_now;
                        count_reg <= '0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (shift_en) begin
                        if (count_reg == IDX_W'(CHANNELS - 1)) begin
                            count_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (shift_en && res.has_result) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, res.changed, res.level, res.slot, res.universe};
                m_tlast_reg  <= is_last;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_stall_holds_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && res.has_result && m_tvalid_reg && !m_tready)
        |=> $stable(count_reg))
        else $error("ring advanced while a report was blocked");

    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (count_reg == '0))
        else $error("walk counter not cleared at idle");

    a_reports_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (shift_en && res.has_result) |-> (item_reg.cmd == CMD_TICK))
        else $error("report produced outside a tick");

    a_last_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (shift_en && res.has_result) |-> mask_reg[count_reg])
        else $error("report from a channel that was not valid at intake");
`endif

endmodule

// ===== design/gdf_cell.sv =====
// One storage cell of the channel ring: holds a single table entry.
// Depends on gdf_pkg for the entry type.

module gdf_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  gdf_pkg::entry_t entry_in,
    output gdf_pkg::entry_t entry_out
);
    import gdf_pkg::*;

    logic   valid_reg;
    entry_t data_reg;

    // Only the valid bit needs a reset; the rest is written by a load first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= entry_in;
        end
    end

    always_comb begin
        entry_out       = data_reg;
        entry_out.valid = valid_reg;
    end

endmodule

// ===== design/gdf_proc.sv =====
// Update logic at the head of the ring: load, telegram match and fade step
// for the one entry passing by. Depends on gdf_pkg.

module gdf_proc (
    input  gdf_pkg::item_t                item,
    input  logic [gdf_pkg::IDX_W-1:0]     pos,
    input  gdf_pkg::entry_t               entry_in,
    output gdf_pkg::entry_t               entry_out,
    output gdf_pkg::result_t              res
);
    import gdf_pkg::*;

    logic [15:0] goal;
    logic [17:0] sum;
    logic        down_ok;
    logic [15:0] diff;
    logic        load_hit;

    assign goal     = {entry_in.target, 8'h00};
    assign sum      = {2'b00, entry_in.fine} + {1'b0, entry_in.step};
    assign down_ok  = {1'b0, entry_in.fine} >= entry_in.step;
    assign diff     = entry_in.fine - entry_in.step[15:0];
    assign load_hit = CMP_W'(pos) == CMP_W'(item.index);

    always_comb begin
        entry_out = entry_in;
        res       = '0;
        case (item.cmd)
            CMD_LOAD: begin
                if (load_hit) begin
                    entry_out.valid    = 1'b1;
                    entry_out.group    = item.group;
                    entry_out.universe = item.universe;
                    entry_out.slot     = item.slot;
                    entry_out.step     = item.step;
                    entry_out.target   = '0;
                    entry_out.fine     = '0;
                    entry_out.shown    = '0;
                end
            end
            CMD_TELEGRAM: begin
                if (item.telegram_ok && entry_in.valid && entry_in.group == item.group) begin
                    entry_out.target = item.value;
                end
            end
            CMD_TICK: begin
                if (entry_in.valid) begin
                    // Move toward the target and clamp; equal integer parts hold still.
                    if (entry_in.shown < entry_in.target) begin
                        entry_out.fine = (sum > {2'b00, goal}) ? goal : sum[15:0];
                    end else if (entry_in.shown > entry_in.target) begin
                        entry_out.fine = (!down_ok || diff < goal) ? goal : diff;
                    end
                    entry_out.shown = entry_out.fine[15:8];
                    res.has_result  = 1'b1;
                    res.universe    = entry_in.universe;
                    res.slot        = entry_in.slot;
                    res.level       = entry_out.shown;
                    res.changed     = entry_out.shown != entry_in.shown;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for group_address_dmx_fader: directed command table, then random
// loads, telegrams and fade ticks checked against an in-bench channel table model.
// Depends on gdf_pkg and the group_address_dmx_fader RTL.
`timescale 1ns / 100ps

module testbench;

    import gdf_pkg::*;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int RANDOM_ITEMS   = 220;
    // Every command walks the whole ring once, so this drain is ample to settle.
    localparam int DRAIN_CYCLES   = 2 * (CHANNELS + 1) + 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AT     = 60;
    localparam int PAUSE_AT       = 150;

    // One command as the sender offers it. When typed is set, the row carries its own
    // expected report count, level and changed flag instead of trusting the model below.
    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  index;
        logic [15:0] group;
        logic [3:0]  universe;
        logic [8:0]  slot;
        logic [16:0] step;
        logic [7:0]  tpci;
        logic [7:0]  apci;
        logic [7:0]  data;
        logic        short_frame;
        logic        typed;
        logic [4:0]  want_n;
        logic [7:0]  want_level;
        logic        want_changed;
    } fader_cmd_t;

    // One level report, as the result channel should deliver it.
    typedef struct packed {
        logic [3:0] universe;
        logic [8:0] slot;
        logic [7:0] level;
        logic       changed;
        logic       last;
    } level_report_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    group_address_dmx_fader dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The bench's own copy of the channel table.
    logic        ch_valid  [CHANNELS];
    logic [15:0] ch_group  [CHANNELS];
    logic [3:0]  ch_universe [CHANNELS];
    logic [8:0]  ch_slot   [CHANNELS];
    logic [16:0] ch_step   [CHANNELS];
    logic [7:0]  ch_target [CHANNELS];
    logic [15:0] ch_fine   [CHANNELS];
    logic [7:0]  ch_shown  [CHANNELS];

    level_report_t level_reports_due[$];
    fader_cmd_t    directed_cmds[$];
    logic [15:0]   group_pool[4];

    int mismatches;
    int cycle_count;
    int reports_checked;
    int level_changes;
    int loads_seen;
    int telegrams_applied;
    int telegrams_rejected;
    int ticks_seen;
    int burst_left;
    bit begin_holdoff;

    // The clock runs free from time zero with a 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost report ends the run here.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("Timeout after %0d cycles, %0d reports still expected.",
                         cycle_count, level_reports_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Every mismatch goes through here: one line in the log, and it is counted.
    task automatic note_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Appends one row to the directed command table.
    task automatic add_row(input fader_cmd_t c);
        directed_cmds = {directed_cmds, c};
    endtask

    function automatic fader_cmd_t load_cmd(input logic [3:0] index, input logic [15:0] group,
                                            input logic [3:0] universe, input logic [8:0] slot,
                                            input logic [16:0] step);
        fader_cmd_t c;
        c = '0;
        c.cmd      = CMD_LOAD;
        c.index    = index;
        c.group    = group;
        c.universe = universe;
        c.slot     = slot;
        c.step     = step;
        return c;
    endfunction

    function automatic fader_cmd_t telegram_cmd(input logic [15:0] group, input logic [7:0] tpci,
                                                input logic [7:0] apci, input logic [7:0] data,
                                                input logic short_frame);
        fader_cmd_t c;
        c = '0;
        c.cmd         = CMD_TELEGRAM;
        c.group       = group;
        c.tpci        = tpci;
        c.apci        = apci;
        c.data        = data;
        c.short_frame = short_frame;
        return c;
    endfunction

    // A tick. With typed set, every report of the tick must carry the given level and
    // changed flag, and the tick must produce exactly want_n reports.
    function automatic fader_cmd_t tick_cmd(input logic typed, input logic [4:0] want_n,
                                            input logic [7:0] want_level,
                                            input logic want_changed);
        fader_cmd_t c;
        c = '0;
        c.cmd          = CMD_TICK;
        c.typed        = typed;
        c.want_n       = want_n;
        c.want_level   = want_level;
        c.want_changed = want_changed;
        return c;
    endfunction

    // Applies one accepted transaction to the bench's channel table and queues the level
    // reports it must cause. Loads and telegrams cause none; a tick causes one per valid
    // channel in entry order, the final one marked last.
    task automatic predict_command(input fader_cmd_t c);
        int            k;
        int            n;
        int            last_k;
        logic [31:0]   goal;
        logic [31:0]   fine;
        logic [31:0]   step;
        logic [7:0]    was;
        logic [7:0]    value;
        level_report_t r;
        n = 0;
        case (c.cmd)
            CMD_LOAD: begin
                // A load always starts the channel dark, whatever it held before.
                loads_seen++;
                if (int'(c.index) < CHANNELS) begin
                    ch_valid[c.index]    = 1'b1;
                    ch_group[c.index]    = c.group;
                    ch_universe[c.index] = c.universe;
                    ch_slot[c.index]     = c.slot;
                    ch_step[c.index]     = c.step;
                    ch_target[c.index]   = 8'd0;
                    ch_fine[c.index]     = 16'd0;
                    ch_shown[c.index]    = 8'd0;
                end
            end
            CMD_TELEGRAM: begin
                // Only a group write with clean TPCI bits touches the targets.
                if ((c.tpci[1:0] & TPCI_CHECK_MASK) == 2'b00
                        && (c.apci & APCI_KIND_MASK) == APCI_WRITE) begin
                    telegrams_applied++;
                    value = c.short_frame ? (c.apci & APCI_SHORT_MASK) : c.data;
                    for (k = 0; k < CHANNELS; k++)
                        if (ch_valid[k] && ch_group[k] == c.group)
                            ch_target[k] = value;
                end else begin
                    telegrams_rejected++;
                end
            end
            CMD_TICK: begin
                ticks_seen++;
                last_k = -1;
                for (k = 0; k < CHANNELS; k++)
                    if (ch_valid[k])
                        last_k = k;
                for (k = 0; k < CHANNELS; k++) begin
                    if (ch_valid[k]) begin
                        was  = ch_shown[k];
                        goal = {24'd0, ch_target[k]} << 8;
                        fine = {16'd0, ch_fine[k]};
                        step = {15'd0, ch_step[k]};
                        // Move toward the target and clamp there. When the integer part
                        // already matches, any fraction is left alone.
                        if (was < ch_target[k]) begin
                            fine = fine + step;
                            if (fine > goal)
                                fine = goal;
                        end else if (was > ch_target[k]) begin
                            if (fine < step || fine - step < goal)
                                fine = goal;
                            else
                                fine = fine - step;
                        end
                        ch_fine[k]  = fine[15:0];
                        ch_shown[k] = fine[15:8];
                        r.universe  = ch_universe[k];
                        r.slot      = ch_slot[k];
                        r.level     = c.typed ? c.want_level : ch_shown[k];
                        r.changed   = c.typed ? c.want_changed : (ch_shown[k] != was);
                        r.last      = (k == last_k);
                        level_reports_due = {level_reports_due, r};
                        n++;
                    end
                end
            end
            default: begin
                // The spare command code is dropped without a trace.
            end
        endcase
        if (c.typed && n != int'(c.want_n))
            note_mismatch($sformatf("directed row wants %0d reports, table holds %0d channels",
                                    c.want_n, n));
    endtask

    // Compares one delivered report with the oldest one still due.
    task automatic check_level_report(input logic [23:0] data, input logic tlast);
        level_report_t want;
        if (level_reports_due.size() == 0) begin
            note_mismatch($sformatf("report %h arrived with none expected", data));
            return;
        end
        want = level_reports_due.pop_front();
        reports_checked++;
        if (data[21])
            level_changes++;
        if (data[3:0] != want.universe)
            note_mismatch($sformatf("universe %0d, expected %0d", data[3:0], want.universe));
        if (data[12:4] != want.slot)
            note_mismatch($sformatf("slot %0d, expected %0d", data[12:4], want.slot));
        if (data[20:13] != want.level)
            note_mismatch($sformatf("level %0d, expected %0d (universe %0d slot %0d)",
                                    data[20:13], want.level, want.universe, want.slot));
        if (data[21] != want.changed)
            note_mismatch($sformatf("changed %0b, expected %0b (universe %0d slot %0d)",
                                    data[21], want.changed, want.universe, want.slot));
        if (tlast != want.last)
            note_mismatch($sformatf("tlast %0b, expected %0b (universe %0d slot %0d)",
                                    tlast, want.last, want.universe, want.slot));
    endtask

    // Result side: sampled at the rising edge, so the values seen are the ones the block
    // held through the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_level_report(m_tdata, m_tlast);
    end

    // Receiver back-pressure. It runs through modes of random length: always ready,
    // coin toss, a fixed one-in-three stall and rare stalls. On request it holds off
    // for a long stretch, counting the cycles itself.
    initial begin
        int holdoff_left;
        int mode;
        int mode_left;
        int phase;
        holdoff_left = 0;
        mode         = 0;
        mode_left    = 0;
        phase        = 0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            phase++;
            if (begin_holdoff) begin
                begin_holdoff = 1'b0;
                holdoff_left  = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= (phase % 3 != 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offers one command and holds it until the block takes it. The sender works in
    // bursts: valid stays high across a burst and drops only for a gap between bursts,
    // so it is never lowered and raised within one time step.
    task automatic send_command(input fader_cmd_t c);
        int gap;
        s_tdata  <= {5'd0, c.short_frame, c.data, c.apci, c.tpci, c.step, c.slot,
                     c.universe, c.group, c.index};
        s_tuser  <= c.cmd;
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_command(c);
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    initial begin
        fader_cmd_t c;
        int         i;
        int         pick;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOAD;
        begin_holdoff   = 1'b0;
        mismatches      = 0;
        reports_checked = 0;
        level_changes   = 0;
        loads_seen      = 0;
        telegrams_applied  = 0;
        telegrams_rejected = 0;
        ticks_seen = 0;
        burst_left = 1;
        for (i = 0; i < CHANNELS; i++) begin
            ch_valid[i]    = 1'b0;
            ch_group[i]    = '0;
            ch_universe[i] = '0;
            ch_slot[i]     = '0;
            ch_step[i]     = '0;
            ch_target[i]   = '0;
            ch_fine[i]     = '0;
            ch_shown[i]    = '0;
        end
        for (i = 0; i < 4; i++)
            group_pool[i] = 16'($urandom);

        // Directed commands. The first ticks have their reports typed in; the rest
        // follow the bench's channel table.
        add_row(tick_cmd(1'b1, 5'd0, 8'd0, 1'b0));                        // empty table
        c = '1;
        c.cmd   = CMD_UNUSED;
        c.typed = 1'b1;
        c.want_n = 5'd0;
        add_row(c);                                                       // spare code
        add_row(load_cmd(4'd0, 16'h0000, 4'd0, 9'd0, 17'h10000));
        add_row(load_cmd(4'd15, 16'hFFFF, 4'd15, 9'd511, 17'h00000));
        add_row(tick_cmd(1'b1, 5'd2, 8'd0, 1'b0));                        // both dark
        add_row(telegram_cmd(16'h0000, 8'hFC, 8'h80, 8'hFF, 1'b0));
        add_row(telegram_cmd(16'hFFFF, 8'h00, 8'hBF, 8'h00, 1'b1));
        add_row(tick_cmd(1'b0, 5'd0, 8'd0, 1'b0));                        // jump, frozen
        add_row(telegram_cmd(16'h0000, 8'h01, 8'h80, 8'h00, 1'b0));
        add_row(telegram_cmd(16'h0000, 8'h02, 8'h80, 8'h00, 1'b0));
        add_row(telegram_cmd(16'h0000, 8'h00, 8'hC0, 8'h00, 1'b0));
        add_row(telegram_cmd(16'h0000, 8'h00, 8'h40, 8'h00, 1'b1));
        add_row(telegram_cmd(16'h1234, 8'h00, 8'h80, 8'h00, 1'b0));
        add_row(tick_cmd(1'b0, 5'd0, 8'd0, 1'b0));                        // nothing moved
        add_row(load_cmd(4'd7, 16'h5A5A, 4'hA, 9'h155, 17'h00180));
        add_row(telegram_cmd(16'h5A5A, 8'h00, 8'h80, 8'h05, 1'b0));
        for (i = 0; i < 4; i++)                                           // 1.5 per tick up
            add_row(tick_cmd(1'b0, 5'd0, 8'd0, 1'b0));
        add_row(telegram_cmd(16'h5A5A, 8'h00, 8'h83, 8'h00, 1'b1));
        for (i = 0; i < 2; i++)                                           // lands on 3.5
            add_row(tick_cmd(1'b0, 5'd0, 8'd0, 1'b0));
        add_row(load_cmd(4'd0, 16'h0000, 4'd1, 9'h0AA, 17'h0FFFF));
        add_row(tick_cmd(1'b0, 5'd0, 8'd0, 1'b0));                        // reload is dark

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_cmds[j])
            send_command(directed_cmds[j]);

        // Random part. Telegrams mostly pass the checks and hit loaded groups, so the
        // levels keep moving; the rest are broken telegrams and stray groups.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            c = '0;
            c.index       = 4'($urandom);
            c.group       = 16'($urandom);
            c.universe    = 4'($urandom);
            c.slot        = 9'($urandom);
            c.step        = 17'($urandom_range(0, 65536));
            c.tpci        = 8'($urandom);
            c.apci        = 8'($urandom);
            c.data        = 8'($urandom);
            c.short_frame = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                c.cmd = CMD_LOAD;
                if ($urandom_range(0, 3) != 0)
                    c.group = group_pool[$urandom_range(0, 3)];
                case ($urandom_range(0, 9))
                    0:       c.step = 17'd0;
                    1, 2:    c.step = 17'h10000;
                    3, 4, 5, 6: c.step = 17'($urandom_range(1, 1024));
                    default: ;
                endcase
            end else if (pick < 50) begin
                c.cmd = CMD_TELEGRAM;
                if ($urandom_range(0, 6) != 0)
                    c.group = group_pool[$urandom_range(0, 3)];
                if ($urandom_range(0, 6) != 0)
                    c.tpci[1:0] = 2'b00;
                if ($urandom_range(0, 6) != 0)
                    c.apci[7:6] = 2'b10;
            end else if (pick < 95) begin
                c.cmd = CMD_TICK;
            end else begin
                c.cmd = CMD_UNUSED;
            end

            // Long receiver hold-off while the sender keeps offering: the ring is held
            // still and the intake has to stall.
            if (i == HOLDOFF_AT)
                begin_holdoff = 1'b1;

            // Sender pause: let every report drain before going on. The previous
            // transaction has just been taken, so valid drops at this falling edge.
            if (i == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                while (level_reports_due.size() != 0)
                    @(posedge aclk);
                @(negedge aclk);
            end

            send_command(c);
        end

        s_tvalid <= 1'b0;
        while (level_reports_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d loads, %0d telegrams applied, %0d rejected, %0d fade ticks.",
                 loads_seen, telegrams_applied, telegrams_rejected, ticks_seen);
        $display("Checked %0d level reports, %0d with a level change; %0d mismatches.",
                 reports_checked, level_changes, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== group_address_dmx_fader.f =====
design/gdf_pkg.sv
design/gdf_cell.sv
design/gdf_proc.sv
design/group_address_dmx_fader.sv
tb/sv/testbench.sv
